FILE: hw/rtl/bpa_pkg.sv
// Package for the bitmap page allocator: sizes, codes, payload types, helpers.
package bpa_pkg;

  localparam int unsigned PAGES      = 4096;
  localparam int unsigned PAGE_SHIFT = 12;
  localparam int unsigned WORD_BITS  = 32;
  localparam int unsigned MAP_WORDS  = PAGES / WORD_BITS;
  localparam int unsigned WORD_W     = $clog2(MAP_WORDS);
  localparam int unsigned BIT_W      = $clog2(WORD_BITS);
  localparam int unsigned PAGE_W     = $clog2(PAGES);
  localparam int unsigned CNT_W      = $clog2(PAGES + 1);
  localparam int unsigned ADDR_W     = 32;

  localparam logic [1:0] CMD_INIT  = 2'd0;
  localparam logic [1:0] CMD_ALLOC = 2'd1;
  localparam logic [1:0] CMD_FREE  = 2'd2;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_NO_PAGE = 2'd1;
  localparam logic [1:0] ST_REJECT  = 2'd2;

  localparam logic REG_BASE = 1'b0;
  localparam logic REG_END  = 1'b1;

  typedef struct packed {
    logic [1:0]        command;
    logic [ADDR_W-1:0] page_address;
  } cmd_t;

  typedef struct packed {
    logic [ADDR_W-1:0] granted_address;
    logic [1:0]        status;
    logic [ADDR_W-1:0] used_bytes;
    logic [ADDR_W-1:0] total_bytes;
  } rsp_t;

  // Page count to bytes, wrapped to 32 bits.
  function automatic logic [ADDR_W-1:0] pages_to_bytes(input logic [CNT_W-1:0] n);
    logic [63:0] wide;
    wide = 64'(n) << PAGE_SHIFT;
    return wide[ADDR_W-1:0];
  endfunction

endpackage

FILE: hw/rtl/bpa_ram.sv
// Generic single-port-write, registered-read RAM.
module bpa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/bitmap_page_allocator.sv
// Alloc searches the map from word 0 upward, one map word a cycle; a free that is rejected
// or ignored skips the map read and write.
// One item is in work at a time; the next is taken the cycle after its result is registered,
// even while that result still waits on rsp_ready.
// Reset (rst, synchronous) clears the per-word valid bits, so the whole map reads as free
// at once; counts, latched region and region registers go to zero. No clearing pass.
module bitmap_page_allocator (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [31:0]      cfg_data,
  input  logic             cmd_valid,
  output logic             cmd_ready,
  input  bpa_pkg::cmd_t    cmd,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output bpa_pkg::rsp_t    rsp
);
  import bpa_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_EXEC    = 3'd1;
  localparam logic [2:0] S_ALLOC   = 3'd2;
  localparam logic [2:0] S_FREE_WR = 3'd3;
  localparam logic [2:0] S_HOLD    = 3'd4;

  // Control state
  logic [2:0]           state;
  logic [2:0]           state_next;
  logic [MAP_WORDS-1:0] row_valid;
  logic                 rd_valid;
  logic [CNT_W-1:0]     page_count;
  logic [CNT_W-1:0]     alloc_count;
  logic [ADDR_W-1:0]    region_base;
  logic [ADDR_W-1:0]    region_end;
  logic [ADDR_W-1:0]    live_base;
  logic [ADDR_W-1:0]    live_end;

  // Item in work
  logic [1:0]           cur_cmd;
  logic [ADDR_W-1:0]    cur_addr;
  logic [WORD_W-1:0]    chk_idx;
  logic [WORD_W-1:0]    free_word;
  logic [BIT_W-1:0]     free_bit;
  logic [ADDR_W-1:0]    res_granted;
  logic [1:0]           res_status;

  // Map memory port
  logic                 mem_we;
  logic [WORD_W-1:0]    mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic [WORD_W-1:0]    mem_raddr;
  logic [WORD_BITS-1:0] mem_rdata;

  // Datapath helpers
  logic [WORD_BITS-1:0] word;
  logic                 word_full;
  logic [BIT_W-1:0]     zero_bit;
  logic [PAGE_W-1:0]    alloc_page;
  logic                 alloc_beyond;
  logic [ADDR_W-1:0]    diff;
  logic [ADDR_W-1:0]    diff_pages;
  logic [CNT_W-1:0]     init_count;
  logic [ADDR_W-1:0]    offset;
  logic [ADDR_W-1:0]    offset_pages;
  logic                 free_bad;
  logic                 free_ignore;
  logic                 rsp_load;

  bpa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign cmd_ready = (state == S_IDLE);
  assign rsp_load  = (state == S_HOLD) && (!rsp_valid || rsp_ready);

  // A word never written since reset or init reads as all free.
  assign word      = rd_valid ? mem_rdata : '0;
  assign word_full = (word == '1);

  // Lowest clear bit of the word under test
  always_comb begin
    zero_bit = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (!word[b]) begin
        zero_bit = BIT_W'(b);
      end
    end
  end

  assign alloc_page   = {chk_idx, zero_bit};
  assign alloc_beyond = (CNT_W'(alloc_page) >= page_count);

  // Page count from the region registers, saturated at PAGES
  assign diff       = region_end - region_base;
  assign diff_pages = diff >> PAGE_SHIFT;
  always_comb begin
    if (region_end <= region_base) begin
      init_count = '0;
    end else if (diff_pages > ADDR_W'(PAGES)) begin
      init_count = CNT_W'(PAGES);
    end else begin
      init_count = diff_pages[CNT_W-1:0];
    end
  end

  // Free address checks against the region latched at init
  assign offset       = cur_addr - live_base;
  assign offset_pages = offset >> PAGE_SHIFT;
  assign free_bad     = (cur_addr < live_base) || (cur_addr >= live_end) ||
                        (offset[PAGE_SHIFT-1:0] != '0);
  assign free_ignore  = (offset_pages >= ADDR_W'(page_count));

  // Next state and memory port
  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_waddr  = chk_idx;
    mem_wdata  = word | (WORD_BITS'(1) << zero_bit);
    mem_raddr  = chk_idx;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        priority if (cur_cmd == CMD_ALLOC) begin
          mem_raddr  = '0;
          state_next = S_ALLOC;
        end else if (cur_cmd == CMD_FREE && !free_bad && !free_ignore) begin
          mem_raddr  = offset_pages[PAGE_W-1:BIT_W];
          state_next = S_FREE_WR;
        end else begin
          state_next = S_HOLD;
        end
      end
      S_ALLOC: begin
        // Prefetch the next word while testing this one.
        mem_raddr = chk_idx + WORD_W'(1);
        if (!word_full) begin
          mem_we     = !alloc_beyond;
          state_next = S_HOLD;
        end else if (chk_idx == WORD_W'(MAP_WORDS - 1)) begin
          state_next = S_HOLD;
        end
      end
      S_FREE_WR: begin
        mem_we     = word[free_bit];
        mem_waddr  = free_word;
        mem_wdata  = word & ~(WORD_BITS'(1) << free_bit);
        mem_raddr  = free_word;
        state_next = S_HOLD;
      end
      S_HOLD: begin
        if (rsp_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      row_valid   <= '0;
      rd_valid    <= 1'b0;
      page_count  <= '0;
      alloc_count <= '0;
      region_base <= '0;
      region_end  <= '0;
      live_base   <= '0;
      live_end    <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= row_valid[mem_raddr];
      if (cfg_we) begin
        unique case (cfg_index)
          REG_BASE: region_base <= cfg_data;
          REG_END:  region_end  <= cfg_data;
          default:  region_base <= region_base;
        endcase
      end
      if (state == S_EXEC && cur_cmd == CMD_INIT) begin
        // Drop every word at once; the map reads as free until rewritten.
        row_valid   <= '0;
        page_count  <= init_count;
        alloc_count <= '0;
        live_base   <= region_base;
        live_end    <= region_end;
      end
      if (mem_we) begin
        row_valid[mem_waddr] <= 1'b1;
      end
      if (state == S_ALLOC && !word_full && !alloc_beyond) begin
        alloc_count <= alloc_count + CNT_W'(1);
      end
      if (state == S_FREE_WR && word[free_bit]) begin
        alloc_count <= alloc_count - CNT_W'(1);
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && cmd_valid) begin
      cur_cmd  <= cmd.command;
      cur_addr <= cmd.page_address;
    end
    unique case (state)
      S_EXEC: begin
        chk_idx     <= '0;
        free_word   <= offset_pages[PAGE_W-1:BIT_W];
        free_bit    <= offset_pages[BIT_W-1:0];
        res_granted <= '0;
        res_status  <= (cur_cmd == CMD_FREE && free_bad) ? ST_REJECT : ST_DONE;
      end
      S_ALLOC: begin
        if (!word_full && !alloc_beyond) begin
          res_granted <= live_base + pages_to_bytes(CNT_W'(alloc_page));
          res_status  <= ST_DONE;
        end else if (!word_full || chk_idx == WORD_W'(MAP_WORDS - 1)) begin
          res_status  <= ST_NO_PAGE;
        end else begin
          chk_idx     <= chk_idx + WORD_W'(1);
        end
      end
      S_IDLE, S_FREE_WR, S_HOLD: begin
        res_status <= res_status;
      end
      default: begin
        res_status <= res_status;
      end
    endcase
    if (rsp_load) begin
      rsp.granted_address <= res_granted;
      rsp.status          <= res_status;
      rsp.used_bytes      <= pages_to_bytes(alloc_count);
      rsp.total_bytes     <= pages_to_bytes(page_count);
    end
  end

endmodule

FILE: hw/rtl/bpa_checker.sv
// Port-level checks for the bitmap page allocator, bound to the top level.
module bpa_checker (
  input logic          clk,
  input logic          rst,
  input logic          cmd_valid,
  input logic          cmd_ready,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input bpa_pkg::rsp_t rsp
);
  import bpa_pkg::*;

  // Hold a stalled result unchanged.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

  // Take one item at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("item taken while another is in work");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.status == ST_DONE || rsp.status == ST_NO_PAGE ||
                  rsp.status == ST_REJECT)
    else $error("undefined status");

  a_fail_no_addr: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_DONE |-> rsp.granted_address == '0)
    else $error("address granted on a failed item");

endmodule

bind bitmap_page_allocator bpa_checker u_bpa_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_ready (cmd_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);
